[rtl/core/tfcp_pkg.sv]
// shared constants, types and width helpers for the thermal false-color palette
package tfcp_pkg;

   localparam int FRACTION_BITS_DEF = 4;
   localparam int QUEUE_DEPTH_DEF   = 4;

   localparam int TEMP_W  = 13;
   localparam int CFG_W   = 9;
   localparam int LEVEL_W = 8;
   localparam int PIXEL_W = 16;
   localparam int QUO_W   = 8;

   // breakpoints in units of 1/10000 of the span
   localparam int FRAC_A   = 2121;
   localparam int FRAC_B   = 3182;
   localparam int FRAC_C   = 4242;
   localparam int FRAC_D   = 8182;
   localparam int FRAC_ONE = 10000;

   localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;
   localparam logic [LEVEL_W-1:0] BLUE_CAP   = 8'd240;

   localparam logic CSR_MIN_TEMP = 1'b0;
   localparam logic CSR_MAX_TEMP = 1'b1;

   typedef enum logic [1:0] {
      MODE_ZERO,
      MODE_FULL,
      MODE_DIV
   } mode_type;

   typedef struct packed {
      mode_type red_mode;
      mode_type green_mode;
      mode_type blue_mode;
      logic     green_down;
      logic     blue_up;
   } ctrl_type;

   // signed width that holds every breakpoint and every scaled sample
   function automatic int cmp_width(int fb);
      return (fb + 24 > 27) ? fb + 24 : 27;
   endfunction

   // unsigned width of the largest ramp denominator
   function automatic int den_width(int fb);
      return fb + 21;
   endfunction

endpackage

[rtl/core/tfcp_front.sv]
// front end: scale registers, breakpoints, sample intake and ramp classification
module tfcp_front #(
   parameter int FRACTION_BITS = tfcp_pkg::FRACTION_BITS_DEF
) (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             csr_we,
   input  logic                                             csr_addr,
   input  logic [tfcp_pkg::CFG_W-1:0]                       csr_wdata,
   input  logic                                             req_tvalid,
   output logic                                             req_tready,
   input  logic signed [tfcp_pkg::TEMP_W-1:0]               req_temp,
   output logic                                             push,
   input  logic                                             q_full,
   output tfcp_pkg::ctrl_type                               push_ctrl,
   output logic [tfcp_pkg::cmp_width(FRACTION_BITS)-1:0]    push_num_r,
   output logic [tfcp_pkg::cmp_width(FRACTION_BITS)-1:0]    push_num_g,
   output logic [tfcp_pkg::cmp_width(FRACTION_BITS)-1:0]    push_num_b,
   output logic [tfcp_pkg::den_width(FRACTION_BITS)-1:0]    den_red,
   output logic [tfcp_pkg::den_width(FRACTION_BITS)-1:0]    den_gup,
   output logic [tfcp_pkg::den_width(FRACTION_BITS)-1:0]    den_gdn,
   output logic [tfcp_pkg::den_width(FRACTION_BITS)-1:0]    den_bdn,
   output logic [tfcp_pkg::den_width(FRACTION_BITS)-1:0]    den_bup
);

   localparam int CW   = tfcp_pkg::cmp_width(FRACTION_BITS);
   localparam int DW   = tfcp_pkg::den_width(FRACTION_BITS);
   localparam int SW   = tfcp_pkg::CFG_W + FRACTION_BITS;
   localparam int UNIT = tfcp_pkg::FRAC_ONE * (1 << FRACTION_BITS);

   logic [tfcp_pkg::CFG_W-1:0] min_ff, min_in, max_ff, max_in, span;
   logic [SW-1:0]              s_val;
   logic [CW-1:0]              m_val;
   logic signed [CW-1:0]       bp_m_ff, bp_a_ff, bp_b_ff, bp_c_ff, bp_d_ff;
   logic signed [CW-1:0]       bp_m_in, bp_a_in, bp_b_in, bp_c_in, bp_d_in;
   logic [DW-1:0]              den_red_in, den_gup_in, den_gdn_in, den_bdn_in, den_bup_in;
   logic                       empty_ff, empty_in;

   logic                       front_valid_ff, front_valid_in;
   logic signed [CW-1:0]       t_ff, t_in;
   logic                       accept;

   // scale registers; writes feed the breakpoints in the same edge
   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (csr_we && csr_addr == tfcp_pkg::CSR_MIN_TEMP) begin
         min_in = csr_wdata;
      end
      if (csr_we && csr_addr == tfcp_pkg::CSR_MAX_TEMP) begin
         max_in = csr_wdata;
      end
   end

   assign span       = max_in - min_in;
   assign s_val      = SW'(span) << FRACTION_BITS;
   assign m_val      = CW'(min_in) * CW'(UNIT);
   assign empty_in   = (max_in <= min_in);
   assign bp_m_in    = $signed(m_val);
   assign bp_a_in    = $signed(m_val + CW'(s_val) * CW'(tfcp_pkg::FRAC_A));
   assign bp_b_in    = $signed(m_val + CW'(s_val) * CW'(tfcp_pkg::FRAC_B));
   assign bp_c_in    = $signed(m_val + CW'(s_val) * CW'(tfcp_pkg::FRAC_C));
   assign bp_d_in    = $signed(m_val + CW'(s_val) * CW'(tfcp_pkg::FRAC_D));
   assign den_red_in = DW'(s_val) * DW'(tfcp_pkg::FRAC_C - tfcp_pkg::FRAC_B);
   assign den_gup_in = DW'(s_val) * DW'(tfcp_pkg::FRAC_A);
   assign den_gdn_in = DW'(s_val) * DW'(tfcp_pkg::FRAC_D - tfcp_pkg::FRAC_C);
   assign den_bdn_in = DW'(s_val) * DW'(tfcp_pkg::FRAC_B - tfcp_pkg::FRAC_A);
   assign den_bup_in = DW'(s_val) * DW'(tfcp_pkg::FRAC_ONE - tfcp_pkg::FRAC_D);

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         max_ff <= tfcp_pkg::CFG_W'(80);
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   // derived values track the scale registers every cycle
   always_ff @(posedge clock) begin
      bp_m_ff  <= bp_m_in;
      bp_a_ff  <= bp_a_in;
      bp_b_ff  <= bp_b_in;
      bp_c_ff  <= bp_c_in;
      bp_d_ff  <= bp_d_in;
      den_red  <= den_red_in;
      den_gup  <= den_gup_in;
      den_gdn  <= den_gdn_in;
      den_bdn  <= den_bdn_in;
      den_bup  <= den_bup_in;
      empty_ff <= empty_in;
   end

   // intake register
   assign req_tready     = !front_valid_ff || !q_full;
   assign accept         = req_tvalid && req_tready;
   assign push           = front_valid_ff && !q_full;
   assign t_in           = CW'(req_temp) * $signed(CW'(tfcp_pkg::FRAC_ONE));
   assign front_valid_in = accept ? 1'b1 : (push ? 1'b0 : front_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         t_ff <= t_in;
      end
   end

   // pick the ramp segment of each channel
   always_comb begin
      push_ctrl.red_mode   = tfcp_pkg::MODE_ZERO;
      push_ctrl.green_mode = tfcp_pkg::MODE_ZERO;
      push_ctrl.blue_mode  = tfcp_pkg::MODE_ZERO;
      push_ctrl.green_down = 1'b0;
      push_ctrl.blue_up    = 1'b0;
      push_num_r           = CW'(t_ff - bp_b_ff);
      push_num_g           = CW'(t_ff - bp_m_ff);
      push_num_b           = CW'(bp_b_ff - t_ff);
      if (!empty_ff) begin
         if (t_ff > bp_b_ff) begin
            push_ctrl.red_mode = tfcp_pkg::MODE_DIV;
         end
         if (t_ff > bp_m_ff && t_ff < bp_a_ff) begin
            push_ctrl.green_mode = tfcp_pkg::MODE_DIV;
         end else if (t_ff >= bp_a_ff && t_ff <= bp_c_ff) begin
            push_ctrl.green_mode = tfcp_pkg::MODE_FULL;
         end else if (t_ff > bp_c_ff && t_ff < bp_d_ff) begin
            push_ctrl.green_mode = tfcp_pkg::MODE_DIV;
            push_ctrl.green_down = 1'b1;
            push_num_g           = CW'(bp_d_ff - t_ff);
         end
         if (t_ff < bp_b_ff) begin
            push_ctrl.blue_mode = tfcp_pkg::MODE_DIV;
         end else if (t_ff > bp_d_ff) begin
            push_ctrl.blue_mode = tfcp_pkg::MODE_DIV;
            push_ctrl.blue_up   = 1'b1;
            push_num_b          = CW'(t_ff - bp_d_ff);
         end
      end
   end

endmodule

[rtl/core/tfcp_queue.sv]
// small first-in first-out queue between the front end and the divide pipeline
module tfcp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = tfcp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;

   assign full  = (count_ff == NW'(DEPTH));
   assign empty = (count_ff == '0);
   assign rdata = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= wdata;
      end
   end

endmodule

[rtl/core/tfcp_back.sv]
// back end: level scaling, eight-step restoring divide per channel, output register
module tfcp_back #(
   parameter int FRACTION_BITS = tfcp_pkg::FRACTION_BITS_DEF
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          q_empty,
   output logic                                          pop,
   input  tfcp_pkg::ctrl_type                            pop_ctrl,
   input  logic [tfcp_pkg::cmp_width(FRACTION_BITS)-1:0] pop_num_r,
   input  logic [tfcp_pkg::cmp_width(FRACTION_BITS)-1:0] pop_num_g,
   input  logic [tfcp_pkg::cmp_width(FRACTION_BITS)-1:0] pop_num_b,
   input  logic [tfcp_pkg::den_width(FRACTION_BITS)-1:0] den_red,
   input  logic [tfcp_pkg::den_width(FRACTION_BITS)-1:0] den_gup,
   input  logic [tfcp_pkg::den_width(FRACTION_BITS)-1:0] den_gdn,
   input  logic [tfcp_pkg::den_width(FRACTION_BITS)-1:0] den_bdn,
   input  logic [tfcp_pkg::den_width(FRACTION_BITS)-1:0] den_bup,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   output logic [tfcp_pkg::PIXEL_W-1:0]                  rsp_pixel,
   output logic [tfcp_pkg::LEVEL_W-1:0]                  rsp_red,
   output logic [tfcp_pkg::LEVEL_W-1:0]                  rsp_green,
   output logic [tfcp_pkg::LEVEL_W-1:0]                  rsp_blue
);

   localparam int CW = tfcp_pkg::cmp_width(FRACTION_BITS);
   localparam int RW = CW + tfcp_pkg::QUO_W;
   localparam int NS = tfcp_pkg::QUO_W;

   logic                        adv;
   logic [NS:0]                 v_ff;
   tfcp_pkg::ctrl_type          ctrl_ff [NS+1];
   logic [RW-1:0]               rem_ff  [NS+1][3];
   logic [tfcp_pkg::QUO_W-1:0]  quo_ff  [NS+1][3];
   logic                        sat_ff  [NS+1][3];
   logic [RW-1:0]               num_scaled [3];
   logic [CW-1:0]               num_raw [3];
   logic [tfcp_pkg::LEVEL_W-1:0] lvl [3];
   logic                        rsp_valid_ff;

   // whole pipeline moves unless a result waits at the output
   assign adv = !rsp_valid_ff || rsp_tready;
   assign pop = adv && !q_empty;

   assign num_raw[0] = pop_num_r;
   assign num_raw[1] = pop_num_g;
   assign num_raw[2] = pop_num_b;

   // 255 * n or 240 * n on the upper blue ramp
   always_comb begin
      num_scaled[0] = (RW'(num_raw[0]) << 8) - RW'(num_raw[0]);
      num_scaled[1] = (RW'(num_raw[1]) << 8) - RW'(num_raw[1]);
      num_scaled[2] = pop_ctrl.blue_up ? (RW'(num_raw[2]) << 8) - (RW'(num_raw[2]) << 4)
                                       : (RW'(num_raw[2]) << 8) - RW'(num_raw[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NS-1:0], pop};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctrl_ff[0] <= pop_ctrl;
         for (int ch = 0; ch < 3; ch++) begin
            rem_ff[0][ch] <= num_scaled[ch];
            quo_ff[0][ch] <= '0;
            sat_ff[0][ch] <= 1'b0;
         end
      end
   end

   for (genvar k = 1; k <= NS; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (adv) begin
            ctrl_ff[k] <= ctrl_ff[k-1];
         end
      end
      for (genvar ch = 0; ch < 3; ch++) begin : g_chan
         logic [RW-1:0] den_ext, dsh, dtop;
         logic          ge, over;
         always_comb begin
            if (ch == 0) begin
               den_ext = RW'(den_red);
            end else if (ch == 1) begin
               den_ext = ctrl_ff[k-1].green_down ? RW'(den_gdn) : RW'(den_gup);
            end else begin
               den_ext = ctrl_ff[k-1].blue_up ? RW'(den_bup) : RW'(den_bdn);
            end
         end
         assign dsh  = den_ext << (NS - k);
         assign dtop = den_ext << NS;
         assign ge   = (rem_ff[k-1][ch] >= dsh);
         // quotient of 256 or more saturates; checked on the first step only
         assign over = (k == 1) ? (rem_ff[k-1][ch] >= dtop) : sat_ff[k-1][ch];
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k][ch] <= ge ? rem_ff[k-1][ch] - dsh : rem_ff[k-1][ch];
               quo_ff[k][ch] <= {quo_ff[k-1][ch][tfcp_pkg::QUO_W-2:0], ge};
               sat_ff[k][ch] <= over;
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         lvl[ch] = sat_ff[NS][ch] ? tfcp_pkg::FULL_LEVEL : quo_ff[NS][ch];
      end
      if (ctrl_ff[NS].blue_up && lvl[2] > tfcp_pkg::BLUE_CAP) begin
         lvl[2] = tfcp_pkg::BLUE_CAP;
      end
      case (ctrl_ff[NS].red_mode)
         tfcp_pkg::MODE_ZERO: lvl[0] = '0;
         tfcp_pkg::MODE_FULL: lvl[0] = tfcp_pkg::FULL_LEVEL;
         tfcp_pkg::MODE_DIV:  lvl[0] = lvl[0];
         default:             lvl[0] = '0;
      endcase
      case (ctrl_ff[NS].green_mode)
         tfcp_pkg::MODE_ZERO: lvl[1] = '0;
         tfcp_pkg::MODE_FULL: lvl[1] = tfcp_pkg::FULL_LEVEL;
         tfcp_pkg::MODE_DIV:  lvl[1] = lvl[1];
         default:             lvl[1] = '0;
      endcase
      case (ctrl_ff[NS].blue_mode)
         tfcp_pkg::MODE_ZERO: lvl[2] = '0;
         tfcp_pkg::MODE_FULL: lvl[2] = tfcp_pkg::FULL_LEVEL;
         tfcp_pkg::MODE_DIV:  lvl[2] = lvl[2];
         default:             lvl[2] = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= v_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_red   <= lvl[0];
         rsp_green <= lvl[1];
         rsp_blue  <= lvl[2];
         rsp_pixel <= {lvl[0][7:3], lvl[1][7:2], lvl[2][7:3]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

[rtl/core/thermal_false_color_palette_top.sv]
// Thermal false-color palette: one temperature sample in, one RGB565 pixel out.
// Throughput is one sample per clock unless the output stalls; an eight-step
// restoring divide pipeline forms each color ramp. min_temp and max_temp are
// written through the csr port; the user writes them only while no sample is in
// flight, not enforced by the block itself. A scale with max_temp not above
// min_temp gives black pixels. The front end and the divide pipeline are joined
// by a short queue, so input and output back-pressure are absorbed separately.
module thermal_false_color_palette_top #(
   parameter int FRACTION_BITS = tfcp_pkg::FRACTION_BITS_DEF,
   parameter int QUEUE_DEPTH   = tfcp_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [8:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // temp_value[12:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // pixel_rgb565, red_level, green_level, blue_level
);

   localparam int CW = tfcp_pkg::cmp_width(FRACTION_BITS);
   localparam int DW = tfcp_pkg::den_width(FRACTION_BITS);
   localparam int QW = $bits(tfcp_pkg::ctrl_type) + 3 * CW;

   logic                   push, pop, q_full, q_empty;
   tfcp_pkg::ctrl_type     push_ctrl, pop_ctrl;
   logic [CW-1:0]          push_num_r, push_num_g, push_num_b;
   logic [CW-1:0]          pop_num_r, pop_num_g, pop_num_b;
   logic [DW-1:0]          den_red, den_gup, den_gdn, den_bdn, den_bup;
   logic [QW-1:0]          q_wdata, q_rdata;
   logic [15:0]            rsp_pixel;
   logic [7:0]             rsp_red, rsp_green, rsp_blue;

   tfcp_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_temp   ($signed(req_tdata[12:0])),
      .push       (push),
      .q_full     (q_full),
      .push_ctrl  (push_ctrl),
      .push_num_r (push_num_r),
      .push_num_g (push_num_g),
      .push_num_b (push_num_b),
      .den_red    (den_red),
      .den_gup    (den_gup),
      .den_gdn    (den_gdn),
      .den_bdn    (den_bdn),
      .den_bup    (den_bup)
   );

   assign q_wdata = {push_ctrl, push_num_r, push_num_g, push_num_b};
   assign {pop_ctrl, pop_num_r, pop_num_g, pop_num_b} = q_rdata;

   tfcp_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   tfcp_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .pop        (pop),
      .pop_ctrl   (pop_ctrl),
      .pop_num_r  (pop_num_r),
      .pop_num_g  (pop_num_g),
      .pop_num_b  (pop_num_b),
      .den_red    (den_red),
      .den_gup    (den_gup),
      .den_gdn    (den_gdn),
      .den_bdn    (den_bdn),
      .den_bup    (den_bup),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_pixel  (rsp_pixel),
      .rsp_red    (rsp_red),
      .rsp_green  (rsp_green),
      .rsp_blue   (rsp_blue)
   );

   assign rsp_tdata = {rsp_blue, rsp_green, rsp_red, rsp_pixel};

endmodule

[rtl/core/tfcp_checker.sv]
// port-level checks for the thermal false-color palette, bound to the top level
module tfcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result beat dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // packed pixel must be the top bits of the three levels
   a_pack: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:11] == rsp_tdata[23:19] &&
                     rsp_tdata[10:5] == rsp_tdata[31:26] &&
                     rsp_tdata[4:0] == rsp_tdata[39:35])
      else $error("pixel packing mismatch");

   // blue above the cap only occurs on the falling ramp, where red is off
   a_blue_red: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[39:32] > 8'd240 |-> rsp_tdata[23:16] == 8'd0)
      else $error("red lit with blue above cap");

endmodule

bind thermal_false_color_palette_top tfcp_checker u_tfcp_checker (.*);
